/* rtl/core/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the 3x3 matrix inverse RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MI3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MI3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mi3_pkg.sv */
// ============================================================================
// mi3_pkg
// Shared constants, types and helpers for the 3x3 matrix inverse.
// ============================================================================
package mi3_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int THR_BITS      = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd1;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_Q_DEPTH   = 4;
    localparam int NUM_ENT       = 9;

    // Cofactor k = a[p]*a[q] - a[r]*a[s], entries indexed row*3+col.
    localparam int COF_IDX [NUM_ENT][4] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic singular;
        logic det_neg;
    } t_mi3_ctrl;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* rtl/core/mi3_if.sv */
// ============================================================================
// mi3_in_if / mi3_out_if
// Valid/ready request channels for matrices in and inverses out.
// ============================================================================
interface mi3_in_if;
    logic valid;
    logic ready;
    logic signed [mi3_pkg::FIELD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
    modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 output ready);
endinterface

interface mi3_out_if;
    logic valid;
    logic ready;
    logic signed [mi3_pkg::FIELD_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic singular;
    logic overflow;

    modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflow, input ready);
    modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 singular, overflow, output ready);
endinterface

/* rtl/core/mi3_front.sv */
// ============================================================================
// mi3_front
// Cofactor and determinant pipeline; classifies each matrix as singular.
// ============================================================================
`include "assert_macros.svh"

module mi3_front #(
    parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mi3_in_if.sink                            i_in,
    input  logic [mi3_pkg::THR_BITS-1:0]      i_thr,
    input  logic                              i_q_full,
    output logic                              o_push,
    output logic [9*(2*WORD_BITS+1)-1:0]      o_cof,
    output logic [3*WORD_BITS+2:0]            o_det_abs,
    output mi3_pkg::t_mi3_ctrl                o_ctrl,
    output logic [9*WORD_BITS-1:0]            o_ent
);
    localparam int W    = WORD_BITS;
    localparam int CW   = 2*W + 1;
    localparam int TW   = 3*W + 1;
    localparam int DW   = 3*W + 3;
    localparam int CMPW = mi3_pkg::max2(DW, mi3_pkg::THR_BITS + 2*FRAC_BITS);
    localparam int NFS  = 6;

    logic               r_vld [NFS];
    logic               f_en;

    logic signed [W-1:0]    a_in [9];
    logic signed [W-1:0]    r_a1 [9], r_a2 [9], r_a3 [9], r_a4 [9], r_a5 [9], r_a6 [9];
    logic signed [2*W-1:0]  r_p2 [18];
    logic signed [CW-1:0]   r_c3 [9], r_c4 [9], r_c5 [9], r_c6 [9];
    logic signed [2*W-1:0]  r_ph4 [3];
    logic signed [2*W+1:0]  r_pl4 [3];
    logic signed [TW-1:0]   r_t5 [3];
    logic signed [DW-1:0]   r_det6;

    logic [DW-1:0]   det_abs;
    logic [CMPW-1:0] thr_sh;

    assign a_in[0] = i_in.a00[W-1:0];
    assign a_in[1] = i_in.a01[W-1:0];
    assign a_in[2] = i_in.a02[W-1:0];
    assign a_in[3] = i_in.a10[W-1:0];
    assign a_in[4] = i_in.a11[W-1:0];
    assign a_in[5] = i_in.a12[W-1:0];
    assign a_in[6] = i_in.a20[W-1:0];
    assign a_in[7] = i_in.a21[W-1:0];
    assign a_in[8] = i_in.a22[W-1:0];

    // The pipeline moves as a whole; it only holds when the last stage is blocked.
    assign f_en       = !r_vld[NFS-1] || !i_q_full;
    assign i_in.ready = f_en;
    assign o_push     = r_vld[NFS-1] && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NFS; s++) r_vld[s] <= 1'b0;
        end else if (f_en) begin
            r_vld[0] <= i_in.valid;
            for (int s = 1; s < NFS; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            for (int k = 0; k < 9; k++) begin
                r_a1[k] <= a_in[k];
                r_a2[k] <= r_a1[k];
                r_a3[k] <= r_a2[k];
                r_a4[k] <= r_a3[k];
                r_a5[k] <= r_a4[k];
                r_a6[k] <= r_a5[k];
                r_p2[2*k]   <= r_a1[mi3_pkg::COF_IDX[k][0]] * r_a1[mi3_pkg::COF_IDX[k][1]];
                r_p2[2*k+1] <= r_a1[mi3_pkg::COF_IDX[k][2]] * r_a1[mi3_pkg::COF_IDX[k][3]];
                r_c3[k] <= $signed({r_p2[2*k][2*W-1], r_p2[2*k]})
                         - $signed({r_p2[2*k+1][2*W-1], r_p2[2*k+1]});
                r_c4[k] <= r_c3[k];
                r_c5[k] <= r_c4[k];
                r_c6[k] <= r_c5[k];
            end
            // First-row expansion, with each cofactor split into a signed high
            // half and an unsigned low half to keep the multipliers narrow.
            for (int j = 0; j < 3; j++) begin
                r_ph4[j] <= r_a3[j] * $signed(r_c3[j][CW-1:W+1]);
                r_pl4[j] <= r_a3[j] * $signed({1'b0, r_c3[j][W:0]});
                r_t5[j]  <= ($signed(TW'(r_ph4[j])) <<< (W+1)) + $signed(TW'(r_pl4[j]));
            end
            r_det6 <= $signed(DW'(r_t5[0])) + $signed(DW'(r_t5[1])) + $signed(DW'(r_t5[2]));
        end
    end

    assign det_abs = r_det6[DW-1] ? DW'(-r_det6) : DW'(r_det6);
    assign thr_sh  = CMPW'({i_thr, {(2*FRAC_BITS){1'b0}}});

    assign o_ctrl.det_neg  = r_det6[DW-1];
    assign o_ctrl.singular = (CMPW'(det_abs) <= thr_sh);
    assign o_det_abs       = det_abs;

    // Output entry (r, c) divides the cofactor of entry (c, r), so the
    // cofactors leave in transposed order.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_cof[(r*3+c)*CW +: CW] = r_c6[c*3+r];
                o_ent[(r*3+c)*W +: W]   = r_a6[r*3+c];
            end
        end
    end

    `MI3_ASSERT_NXT(a_front_hold, i_clk, i_rst_n, r_vld[NFS-1] && i_q_full, r_vld[NFS-1] && $stable(r_det6), "blocked determinant stage changed")

endmodule

/* rtl/core/mi3_queue.sv */
// ============================================================================
// mi3_queue
// Small register FIFO between the determinant front and the divider back.
// ============================================================================
`include "assert_macros.svh"

module mi3_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = mi3_pkg::DEF_Q_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [DATA_BITS-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_wp, r_rp;
    logic [NW-1:0]        r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    `MI3_ASSERT_IMP(a_q_no_overfill, i_clk, i_rst_n, i_push, !o_full, "request pushed into full queue")
    `MI3_ASSERT_IMP(a_q_no_underrun, i_clk, i_rst_n, i_pop, !o_empty, "request popped from empty queue")

endmodule

/* rtl/core/mi3_back.sv */
// ============================================================================
// mi3_back
// Pipelined restoring divider over nine lanes, saturation and output stage.
// ============================================================================
`include "assert_macros.svh"

module mi3_back #(
    parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [9*(2*WORD_BITS+1)-1:0]  i_cof,
    input  logic [3*WORD_BITS+2:0]        i_det_abs,
    input  mi3_pkg::t_mi3_ctrl            i_ctrl,
    input  logic [9*WORD_BITS-1:0]        i_ent,
    mi3_out_if.source                     o_out
);
    localparam int W    = WORD_BITS;
    localparam int FB   = mi3_pkg::FIELD_BITS;
    localparam int CW   = 2*W + 1;
    localparam int DW   = 3*W + 3;
    localparam int NW   = CW + 2*FRAC_BITS;
    localparam int XW   = mi3_pkg::max2(NW, DW + W + 2);
    localparam int QW   = W + 2;
    localparam int NS   = W + 3;
    localparam int LAST = NS - 1;

    logic               b_en;
    logic               r_v    [NS];
    logic [XW-1:0]      r_rem  [NS][9];
    logic [XW-1:0]      n_rem  [NS][9];
    logic [QW-1:0]      r_q    [NS][9];
    logic [QW-1:0]      n_q    [NS][9];
    logic               r_neg  [NS][9];
    logic               n_neg  [NS][9];
    logic [DW-1:0]      r_d    [NS];
    logic               r_sing [NS];
    logic [9*W-1:0]     r_ent  [NS];

    logic               r_ov;
    logic [FB-1:0]      r_res [9];
    logic [FB-1:0]      n_res [9];
    logic               r_sing_o, r_ovf_o, n_ovf;

    assign b_en  = !r_ov || o_out.ready;
    assign o_pop = b_en && !i_empty;

    // Stage 0 loads |cofactor| scaled by 2^(2F); stage s tests the divisor
    // shifted by W+2-s, so the first test flags a quotient of 2^(W+1) or more.
    always_comb begin
        logic signed [CW-1:0] cf;
        logic [CW-1:0]        cf_abs;
        logic [XW-1:0]        d_sh;
        for (int k = 0; k < 9; k++) begin
            cf          = $signed(i_cof[k*CW +: CW]);
            cf_abs      = cf[CW-1] ? CW'(-cf) : CW'(cf);
            n_rem[0][k] = XW'(cf_abs) << (2*FRAC_BITS);
            n_q[0][k]   = '0;
            n_neg[0][k] = cf[CW-1] ^ i_ctrl.det_neg;
        end
        for (int s = 1; s < NS; s++) begin
            for (int k = 0; k < 9; k++) begin
                d_sh        = XW'(r_d[s-1]) << (W + 2 - s);
                n_neg[s][k] = r_neg[s-1][k];
                if (r_rem[s-1][k] >= d_sh) begin
                    n_rem[s][k] = r_rem[s-1][k] - d_sh;
                    n_q[s][k]   = r_q[s-1][k] | (QW'(1) << (W + 2 - s));
                end else begin
                    n_rem[s][k] = r_rem[s-1][k];
                    n_q[s][k]   = r_q[s-1][k];
                end
            end
        end
    end

    always_comb begin
        logic [QW-1:0] q;
        logic          sat;
        logic [W-1:0]  val;
        n_ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            q = r_q[LAST][k];
            if (r_neg[LAST][k]) begin
                sat = q[W+1] || q[W] || (q[W-1] && (q[W-2:0] != '0));
                val = sat ? {1'b1, {(W-1){1'b0}}} : W'(-q[W-1:0]);
            end else begin
                sat = q[W+1] || q[W] || q[W-1];
                val = sat ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
            end
            if (r_sing[LAST]) begin
                n_res[k] = FB'($signed(r_ent[LAST][k*W +: W]));
            end else begin
                n_res[k] = FB'($signed(val));
                n_ovf    = n_ovf | sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (b_en) begin
            r_v[0] <= !i_empty;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
            r_ov <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_rem     <= n_rem;
            r_q       <= n_q;
            r_neg     <= n_neg;
            r_d[0]    <= i_det_abs;
            r_sing[0] <= i_ctrl.singular;
            r_ent[0]  <= i_ent;
            for (int s = 1; s < NS; s++) begin
                r_d[s]    <= r_d[s-1];
                r_sing[s] <= r_sing[s-1];
                r_ent[s]  <= r_ent[s-1];
            end
            r_res    <= n_res;
            r_sing_o <= r_sing[LAST];
            r_ovf_o  <= n_ovf;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.r00      = r_res[0];
    assign o_out.r01      = r_res[1];
    assign o_out.r02      = r_res[2];
    assign o_out.r10      = r_res[3];
    assign o_out.r11      = r_res[4];
    assign o_out.r12      = r_res[5];
    assign o_out.r20      = r_res[6];
    assign o_out.r21      = r_res[7];
    assign o_out.r22      = r_res[8];
    assign o_out.singular = r_sing_o;
    assign o_out.overflow = r_ovf_o;

    `MI3_ASSERT_IMP(a_back_sing_no_ovf, i_clk, i_rst_n, r_ov && r_sing_o, !r_ovf_o, "singular result flagged overflow")

endmodule

/* rtl/core/matrix3_inverse_unit.sv */
// ============================================================================
// matrix3_inverse_unit
// Inverse of a signed fixed-point 3x3 matrix by the adjugate method.
// ============================================================================
// Takes one matrix request per cycle and returns one result per cycle in
// order while the output is not held. Six stages form the cofactors and
// determinant, the queue registers each request, a load stage and
// WORD_BITS + 2 stages of a nine-lane restoring divider retire one quotient
// bit each, and the result sits in an output register. The queue between
// the determinant and divider pipelines lets the input keep accepting up to
// QUEUE_DEPTH + 6 requests while the output is held. Results are truncated
// toward zero and saturated; a matrix whose determinant magnitude is at or
// below the threshold register comes back unchanged with singular set.

module matrix3_inverse_unit #(
    parameter int WORD_BITS   = mi3_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS   = mi3_pkg::DEF_FRAC_BITS,
    parameter int QUEUE_DEPTH = mi3_pkg::DEF_Q_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mi3_pkg::THR_BITS-1:0]  i_cfg_wdata,
    mi3_in_if.sink                        i_in,
    mi3_out_if.source                     o_out
);
    localparam int W   = WORD_BITS;
    localparam int CW  = 2*W + 1;
    localparam int DW  = 3*W + 3;
    localparam int CTW = $bits(mi3_pkg::t_mi3_ctrl);
    localparam int PW  = CTW + DW + 9*CW + 9*W;

    logic [mi3_pkg::THR_BITS-1:0] r_thr;

    logic                 push, q_full, pop, q_empty;
    logic [9*CW-1:0]      f_cof, b_cof;
    logic [DW-1:0]        f_det, b_det;
    mi3_pkg::t_mi3_ctrl   f_ctrl, b_ctrl;
    logic [9*W-1:0]       f_ent, b_ent;
    logic [PW-1:0]        q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mi3_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    mi3_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_thr     (r_thr),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cof     (f_cof),
        .o_det_abs (f_det),
        .o_ctrl    (f_ctrl),
        .o_ent     (f_ent)
    );

    assign q_wdata = {f_ctrl, f_det, f_cof, f_ent};

    mi3_queue #(
        .DATA_BITS (PW),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign {b_ctrl, b_det, b_cof, b_ent} = q_rdata;

    mi3_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .o_pop     (pop),
        .i_cof     (b_cof),
        .i_det_abs (b_det),
        .i_ctrl    (b_ctrl),
        .i_ent     (b_ent),
        .o_out     (o_out)
    );

endmodule
